// ===== rtl/nwt_pkg.sv =====
// ----------------------------------------------------------------------------
// nwt_pkg
// Types and codes shared by the nearest waypoint trim unit.
// ----------------------------------------------------------------------------
package nwt_pkg;

  localparam int unsigned MaxPoints = 1024;

  localparam int unsigned CoordW = 24;
  localparam int unsigned DistW  = 49;
  localparam int unsigned IndexW = 10;
  localparam int unsigned RemainW = 11;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MALFORMED  = 2'd1;
  localparam logic [1:0] ST_BAD_ODOM   = 2'd2;
  localparam logic [1:0] ST_OVER_CAP   = 2'd3;

  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic                     coords_valid;
    logic                     last;
  } nwt_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IndexW-1:0]  wp_index;
    logic [RemainW-1:0] remaining_points;
  } nwt_out_t;

  // classified waypoint record passed from front to back
  typedef struct packed {
    logic             is_point;
    logic             searched;
    logic             bad;
    logic             seg_gt;
    logic             ego_ok;
    logic             last;
    logic [DistW-1:0] ego_sq;
  } nwt_rec_t;

endpackage

// ===== rtl/nwt_fifo.sv =====
// ----------------------------------------------------------------------------
// nwt_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module nwt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH)) else $error("fifo count overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("fifo pointers out of step with count");

endmodule

// ===== rtl/nwt_front.sv =====
// ----------------------------------------------------------------------------
// nwt_front
// Accepts items, keeps vehicle and previous point, forms squared distances.
// ----------------------------------------------------------------------------
module nwt_front #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned CNT_W      = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [48:0]          cfg_wdata_i,
  input  logic                 take_i,
  input  nwt_pkg::nwt_in_t     item_i,
  output nwt_pkg::nwt_rec_t    rec_o,
  output logic [CNT_W-1:0]     count_o
);

  import nwt_pkg::*;

  logic [DistW-1:0]         min_seg_q;
  logic signed [CoordW-1:0] ego_x_q, ego_y_q, prev_x_q, prev_y_q;
  logic                     ego_ok_q;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     is_point, in_cap;
  logic [DistW-1:0]         ego_dist, seg_dist;

  function automatic logic [DistW-1:0] sq_dist(
    input logic [CoordW-1:0] ax, input logic [CoordW-1:0] ay,
    input logic [CoordW-1:0] bx, input logic [CoordW-1:0] by
  );
    logic [CoordW:0]     dx, dy;
    logic [CoordW-1:0]   ux, uy;
    logic [2*CoordW-1:0] sx, sy;
    dx = {ax[CoordW-1], ax} - {bx[CoordW-1], bx};
    dy = {ay[CoordW-1], ay} - {by[CoordW-1], by};
    ux = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
    uy = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
    sx = ux * ux;
    sy = uy * uy;
    return {1'b0, sx} + {1'b0, sy};
  endfunction

  assign is_point = (item_i.kind == KIND_POINT);
  assign in_cap   = (cnt_q < CNT_W'(MAX_POINTS));
  assign ego_dist = sq_dist(item_i.coord_x, item_i.coord_y, ego_x_q, ego_y_q);
  assign seg_dist = sq_dist(item_i.coord_x, item_i.coord_y, prev_x_q, prev_y_q);

  always_comb begin
    if (!is_point) begin
      cnt_d = '0;
    end else if (cnt_q <= CNT_W'(MAX_POINTS)) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_comb begin
    rec_o.is_point = is_point;
    rec_o.searched = is_point && in_cap && item_i.coords_valid;
    rec_o.bad      = is_point && in_cap && !item_i.coords_valid;
    rec_o.seg_gt   = is_point && in_cap && item_i.coords_valid && (cnt_q != '0) &&
                     (seg_dist > min_seg_q);
    rec_o.ego_ok   = is_point ? ego_ok_q : item_i.coords_valid;
    rec_o.last     = item_i.last;
    rec_o.ego_sq   = ego_dist;
  end

  assign count_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_seg_q <= '0;
      ego_x_q   <= '0;
      ego_y_q   <= '0;
      ego_ok_q  <= 1'b0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        min_seg_q <= cfg_wdata_i;
      end
      if (take_i) begin
        if (item_i.last) begin
          ego_x_q  <= '0;
          ego_y_q  <= '0;
          ego_ok_q <= 1'b0;
          prev_x_q <= '0;
          prev_y_q <= '0;
          cnt_q    <= '0;
        end else if (!is_point) begin
          ego_x_q  <= item_i.coord_x;
          ego_y_q  <= item_i.coord_y;
          ego_ok_q <= item_i.coords_valid;
          prev_x_q <= '0;
          prev_y_q <= '0;
          cnt_q    <= '0;
        end else begin
          if (in_cap) begin
            prev_x_q <= item_i.coord_x;
            prev_y_q <= item_i.coord_y;
          end
          cnt_q <= cnt_d;
        end
      end
    end
  end

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS + 1)) else $error("point count past saturation");

  a_prev_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && is_point && !in_cap && !item_i.last) |=>
      ($stable(prev_x_q) && $stable(prev_y_q)))
    else $error("previous point moved beyond capacity");

endmodule

// ===== rtl/nwt_back.sv =====
// ----------------------------------------------------------------------------
// nwt_back
// Keeps the running nearest waypoint and forms the status on the last item.
// ----------------------------------------------------------------------------
module nwt_back #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned CNT_W      = 11,
  parameter int unsigned IDX_W      = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rec_valid_i,
  input  nwt_pkg::nwt_rec_t rec_i,
  input  logic [CNT_W-1:0]  count_i,
  output logic              rec_take_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output nwt_pkg::nwt_out_t res_o
);

  import nwt_pkg::*;

  logic [DistW-1:0] best_d_q, best_d_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic             seg_q, seg_d, bad_q, bad_d;
  logic [IDX_W-1:0] cur_idx;
  logic [CNT_W-1:0] span;

  assign rec_take_o = rec_valid_i && (!rec_i.last || !res_full_i);
  assign res_push_o = rec_take_o && rec_i.last;
  assign cur_idx    = IDX_W'(count_i - 1'b1);

  always_comb begin
    best_d_d   = best_d_q;
    best_idx_d = best_idx_q;
    seg_d      = seg_q;
    bad_d      = bad_q;
    if (!rec_i.is_point) begin
      best_d_d   = '1;
      best_idx_d = '0;
      seg_d      = 1'b0;
      bad_d      = 1'b0;
    end else begin
      bad_d = bad_q || rec_i.bad;
      seg_d = seg_q || rec_i.seg_gt;
      if (rec_i.searched && (rec_i.ego_sq < best_d_q)) begin
        best_d_d   = rec_i.ego_sq;
        best_idx_d = cur_idx;
        seg_d      = 1'b0;
      end
    end
  end

  assign span = count_i - CNT_W'(best_idx_d);

  always_comb begin
    res_o.status           = ST_OK;
    res_o.wp_index         = '0;
    res_o.remaining_points = '0;
    if (count_i < CNT_W'(2)) begin
      res_o.status = ST_MALFORMED;
    end else if (count_i > CNT_W'(MAX_POINTS)) begin
      res_o.status = ST_OVER_CAP;
    end else if (!rec_i.ego_ok) begin
      res_o.status = ST_BAD_ODOM;
    end else if (bad_d) begin
      res_o.status = ST_MALFORMED;
    end else if (span < CNT_W'(2) || !seg_d) begin
      res_o.status   = ST_MALFORMED;
      res_o.wp_index = IndexW'(best_idx_d);
    end else begin
      res_o.wp_index         = IndexW'(best_idx_d);
      res_o.remaining_points = RemainW'(span);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_d_q   <= '1;
      best_idx_q <= '0;
      seg_q      <= 1'b0;
      bad_q      <= 1'b0;
    end else if (rec_take_o) begin
      if (rec_i.last) begin
        best_d_q   <= '1;
        best_idx_q <= '0;
        seg_q      <= 1'b0;
        bad_q      <= 1'b0;
      end else begin
        best_d_q   <= best_d_d;
        best_idx_q <= best_idx_d;
        seg_q      <= seg_d;
        bad_q      <= bad_d;
      end
    end
  end

  a_idx_needs_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_idx_q != '0) |-> (best_d_q != '1))
    else $error("nearest index set without a distance");

  a_seg_needs_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q |-> (best_d_q != '1)) else $error("segment flag set before any nearest point");

endmodule

// ===== rtl/nearest_waypoint_trim_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_waypoint_trim_unit
// Nearest waypoint search over a streamed polyline with segment check.
// ----------------------------------------------------------------------------
//  channel   handshake        payload                 direction
//  input     push / full      in_i  (nwt_in_t)        in
//  result    pop / empty      out_o (nwt_out_t)       out
//  config    cfg_we_i         cfg_wdata_i (49 bits)   in
//
//  one item per cycle unless the input queue is full; a result reaches out_o
//  via the record queue and result queue once its last item is accepted
//  the front squares four coordinate differences, the back does one 49-bit
//  compare per item
//  a two-entry queue sits between front and back, another on the result side
//  reset clears all path state; no clearing pass
//  a full result queue holds a last item in the back, and the input queue
//  fills behind it
// ----------------------------------------------------------------------------
module nearest_waypoint_trim_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [48:0]       cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  nwt_pkg::nwt_in_t  in_i,
  input  logic              pop,
  output logic              empty,
  output nwt_pkg::nwt_out_t out_o
);

  import nwt_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxPoints + 2);
  localparam int unsigned IdxW  = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned QW    = $bits(nwt_rec_t) + CntW;
  localparam int unsigned OutW  = $bits(nwt_out_t);

  logic             take;
  nwt_rec_t         f_rec, b_rec;
  logic [CntW-1:0]  f_cnt, b_cnt;
  logic [QW-1:0]    q_out;
  logic             q_empty, b_take, res_full, res_push;
  nwt_out_t         res;
  logic [OutW-1:0]  res_q_out;

  assign take = push && !full;

  nwt_front #(
    .MAX_POINTS (MaxPoints),
    .CNT_W      (CntW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (in_i),
    .rec_o       (f_rec),
    .count_o     (f_cnt)
  );

  nwt_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_rec_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_rec, f_cnt}),
    .full_o  (full),
    .pop_i   (b_take),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign b_rec = q_out[QW-1:CntW];
  assign b_cnt = q_out[CntW-1:0];

  nwt_back #(
    .MAX_POINTS (MaxPoints),
    .CNT_W      (CntW),
    .IDX_W      (IdxW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!q_empty),
    .rec_i       (b_rec),
    .count_i     (b_cnt),
    .rec_take_o  (b_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  nwt_fifo #(
    .WIDTH (OutW),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_q_out),
    .empty_o (empty)
  );

  assign out_o = res_q_out;

endmodule
